// ----- sv/kdce_pkg.sv -----
package kdce_pkg;

  localparam int unsigned CODE_LEN_DEF = 4;

  localparam int unsigned KEY_W   = 4;
  localparam int unsigned DEC_W   = 5;
  localparam int unsigned COUNT_W = 5;
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned CFG_DATA_W = 4;

  localparam logic [DEC_W-1:0]   NO_KEY    = 5'd16;
  localparam logic [COUNT_W-1:0] COUNT_MAX = 5'd31;

  localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_ENTER     = 1'b1;

  localparam logic [KEY_W-1:0] THRESHOLD_RST = 4'd2;
  localparam logic [KEY_W-1:0] ENTER_RST     = 4'd11;

  localparam int unsigned Q_DEPTH = 2;
  localparam int unsigned Q_PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int unsigned Q_CNT_W = $clog2(Q_DEPTH + 1);

  typedef enum logic [1:0] {
    CMD_REPORT,
    CMD_STORE,
    CMD_SEND
  } cmd_op_e;

  typedef struct packed {
    cmd_op_e          op;
    logic [KEY_W-1:0] key;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  // Key codes, indexed [column][row]
  localparam logic [KEY_W-1:0] KEY_TABLE [4][4] = '{
    '{4'd1,  4'd4,  4'd7,  4'd10},
    '{4'd2,  4'd5,  4'd8,  4'd0},
    '{4'd3,  4'd6,  4'd9,  4'd11},
    '{4'd12, 4'd13, 4'd14, 4'd15}
  };

  function automatic logic [DEC_W-1:0] decode_key(input logic [1:0] col,
                                                  input logic [3:0] rows);
    logic [DEC_W-1:0] res;
    logic             found;
    res   = NO_KEY;
    found = 1'b0;
    for (int i = 0; i < 4; i++) begin
      if (rows[i] && !found) begin
        res   = {1'b0, KEY_TABLE[col][i]};
        found = 1'b1;
      end
    end
    return res;
  endfunction

endpackage

// ----- sv/kdce_front.sv -----
module kdce_front #(
  parameter int unsigned CODE_LEN = kdce_pkg::CODE_LEN_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [kdce_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [kdce_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [1:0]                      column_i,
  input  logic [3:0]                      row_lines_i,
  input  kdce_pkg::q_status_t             q_status_i,
  output logic                            push_o,
  output kdce_pkg::cmd_t                  cmd_o
);

  localparam int unsigned CNT_W = $clog2(CODE_LEN + 1);
  localparam logic [CNT_W-1:0] CODE_LEN_C = CNT_W'(CODE_LEN);

  logic [kdce_pkg::KEY_W-1:0]   thr_q, enter_q;
  logic [kdce_pkg::DEC_W-1:0]   prev_q, prev_d;
  logic [kdce_pkg::COUNT_W-1:0] mc_q, mc_d, mc_inc;
  logic                         armed_q, armed_d;
  logic [CNT_W-1:0]             dc_q, dc_d;
  logic [kdce_pkg::DEC_W-1:0]   key;
  logic                         accept;
  logic                         emit;
  kdce_pkg::cmd_op_e            op;

  assign in_ready_o = !q_status_i.full;
  assign accept     = in_valid_i && in_ready_o;
  assign key        = kdce_pkg::decode_key(column_i, row_lines_i);

  always_comb begin
    mc_inc = mc_q;
    if (key != kdce_pkg::NO_KEY && key == prev_q && mc_q < kdce_pkg::COUNT_MAX) begin
      mc_inc = mc_q + 1'b1;
    end
    mc_d    = mc_inc;
    armed_d = armed_q;
    dc_d    = dc_q;
    emit    = 1'b0;
    op      = kdce_pkg::CMD_REPORT;
    prev_d  = key;
    if (mc_inc > {1'b0, thr_q}) begin
      if (armed_q) begin
        if (key != kdce_pkg::NO_KEY) begin
          emit = 1'b1;
          if (key[kdce_pkg::KEY_W-1:0] == enter_q && dc_q >= CODE_LEN_C) begin
            op   = kdce_pkg::CMD_SEND;
            dc_d = '0;
          end else if (dc_q < CODE_LEN_C) begin
            op   = kdce_pkg::CMD_STORE;
            dc_d = dc_q + 1'b1;
          end
        end
        armed_d = 1'b0;
      end
      if (prev_q != key) begin
        mc_d = '0;
      end
    end else begin
      armed_d = 1'b1;
    end
  end

  assign push_o     = accept && emit;
  assign cmd_o.op   = op;
  assign cmd_o.key  = key[kdce_pkg::KEY_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q   <= kdce_pkg::THRESHOLD_RST;
      enter_q <= kdce_pkg::ENTER_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        kdce_pkg::CFG_THRESHOLD: thr_q   <= cfg_data_i;
        kdce_pkg::CFG_ENTER:     enter_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q  <= '0;
      mc_q    <= '0;
      armed_q <= 1'b0;
      dc_q    <= '0;
    end else if (accept) begin
      prev_q  <= prev_d;
      mc_q    <= mc_d;
      armed_q <= armed_d;
      dc_q    <= dc_d;
    end
  end

endmodule

// ----- sv/kdce_queue.sv -----
module kdce_queue (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  kdce_pkg::cmd_t      push_data_i,
  input  logic                pop_i,
  output kdce_pkg::cmd_t      pop_data_o,
  output kdce_pkg::q_status_t status_o
);

  kdce_pkg::cmd_t                 mem_q [kdce_pkg::Q_DEPTH];
  logic [kdce_pkg::Q_PTR_W-1:0]   wr_q, rd_q;
  logic [kdce_pkg::Q_CNT_W-1:0]   cnt_q;
  logic                           do_push, do_pop;

  localparam logic [kdce_pkg::Q_PTR_W-1:0] LAST_PTR = kdce_pkg::Q_PTR_W'(kdce_pkg::Q_DEPTH - 1);
  localparam logic [kdce_pkg::Q_CNT_W-1:0] DEPTH_C  = kdce_pkg::Q_CNT_W'(kdce_pkg::Q_DEPTH);

  assign status_o.full  = (cnt_q == DEPTH_C);
  assign status_o.empty = (cnt_q == '0);
  assign do_push = push_i && !status_o.full;
  assign do_pop  = pop_i && !status_o.empty;
  assign pop_data_o = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= (wr_q == LAST_PTR) ? '0 : wr_q + 1'b1;
      end
      if (do_pop) begin
        rd_q <= (rd_q == LAST_PTR) ? '0 : rd_q + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   cnt_q <= cnt_q + 1'b1;
        2'b01:   cnt_q <= cnt_q - 1'b1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

// ----- sv/kdce_back.sv -----
module kdce_back #(
  parameter int unsigned CODE_LEN = kdce_pkg::CODE_LEN_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  kdce_pkg::q_status_t        q_status_i,
  input  kdce_pkg::cmd_t             cmd_i,
  output logic                       pop_o,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic                       kind_o,
  output logic [kdce_pkg::KEY_W-1:0] value_o,
  output logic                       last_o
);

  localparam int unsigned IDX_W = (CODE_LEN > 1) ? $clog2(CODE_LEN) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CODE_LEN - 1);

  logic [kdce_pkg::KEY_W-1:0] store_q [CODE_LEN];
  logic [IDX_W-1:0]           wp_q, cnt_q;
  logic                       send_q;
  logic                       valid_q, kind_q, last_q;
  logic [kdce_pkg::KEY_W-1:0] value_q;
  logic                       load;

  assign load  = !valid_q || out_ready_i;
  assign pop_o = load && !send_q && !q_status_i.empty;

  assign out_valid_o = valid_q;
  assign kind_o      = kind_q;
  assign value_o     = value_q;
  assign last_o      = last_q;

  always_ff @(posedge clk_i) begin
    if (pop_o && cmd_i.op == kdce_pkg::CMD_STORE) begin
      store_q[wp_q] <= cmd_i.key;
    end
  end

  // Payload registers: report beat from the queue, or the next stored digit
  always_ff @(posedge clk_i) begin
    if (load && send_q) begin
      kind_q  <= 1'b1;
      value_q <= store_q[cnt_q];
      last_q  <= (cnt_q == LAST_IDX);
    end else if (pop_o) begin
      kind_q  <= 1'b0;
      value_q <= cmd_i.key;
      last_q  <= (cmd_i.op != kdce_pkg::CMD_SEND);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      send_q  <= 1'b0;
      cnt_q   <= '0;
      wp_q    <= '0;
    end else if (load) begin
      if (send_q) begin
        valid_q <= 1'b1;
        cnt_q   <= cnt_q + 1'b1;
        if (cnt_q == LAST_IDX) begin
          send_q <= 1'b0;
        end
      end else if (pop_o) begin
        valid_q <= 1'b1;
        case (cmd_i.op)
          kdce_pkg::CMD_STORE: wp_q <= wp_q + 1'b1;
          kdce_pkg::CMD_SEND: begin
            send_q <= 1'b1;
            cnt_q  <= '0;
            wp_q   <= '0;
          end
          default: ;
        endcase
      end else begin
        valid_q <= 1'b0;
      end
    end
  end

endmodule

// ----- sv/keypad_debounce_code_entry_unit.sv -----
// Keypad debounce and code entry.
// Input stream (s_axis): one beat per keypad column event; tdata carries the
// column index and the sensed row lines. Beats are taken one per cycle while
// the two-entry command queue has room.
// Output stream (m_axis): key press reports (tuser 0) and, when the enter key
// is pressed with a full code store, the stored digits oldest first
// (tuser 1). tlast marks the final beat caused by one input event.
// A reporting event passes through the command queue and then the output
// register before its first output beat shows. A report gives one output beat;
// a code send gives 1 + CODE_LEN beats from the single output register that the
// back end drives one beat per cycle while the receiver is ready.
// Events that produce no beat update the debounce state and leave nothing
// behind; throughput is one event per cycle as long as the output drains.
// When the receiver stalls, the output beat holds, the queue fills and then
// s_axis_tready drops; no beat is lost. Reset clears the debounce state, digit
// count, queue and output, and loads debounce_threshold = 2 and enter_key = 11.
// Configuration: cfg_we_i writes cfg_data_i to register cfg_idx_i (0 threshold,
// 1 enter key); the user writes only while idle, the block does not enforce it.
module keypad_debounce_code_entry_unit #(
  parameter int unsigned CODE_LEN = kdce_pkg::CODE_LEN_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [kdce_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [kdce_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [7:0]                      s_axis_tdata,  // [1:0] column, [5:2] row_lines
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [7:0]                      m_axis_tdata,  // [3:0] value
  output logic                            m_axis_tuser,  // [0] kind
  output logic                            m_axis_tlast
);

  kdce_pkg::q_status_t        q_status;
  kdce_pkg::cmd_t             push_cmd, pop_cmd;
  logic                       push, pop;
  logic [kdce_pkg::KEY_W-1:0] value;

  kdce_front #(.CODE_LEN(CODE_LEN)) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .column_i    (s_axis_tdata[1:0]),
    .row_lines_i (s_axis_tdata[5:2]),
    .q_status_i  (q_status),
    .push_o      (push),
    .cmd_o       (push_cmd)
  );

  kdce_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_cmd),
    .pop_i       (pop),
    .pop_data_o  (pop_cmd),
    .status_o    (q_status)
  );

  kdce_back #(.CODE_LEN(CODE_LEN)) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_status_i  (q_status),
    .cmd_i       (pop_cmd),
    .pop_o       (pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .kind_o      (m_axis_tuser),
    .value_o     (value),
    .last_o      (m_axis_tlast)
  );

  assign m_axis_tdata = {4'b0000, value};

endmodule

// ----- sv/kdce_checker.sv -----
module kdce_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       m_axis_tvalid,
  input logic       m_axis_tready,
  input logic [7:0] m_axis_tdata,
  input logic       m_axis_tuser,
  input logic       m_axis_tlast
);

  // A stalled output beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) &&
      $stable(m_axis_tlast))
    else $error("output beat changed while stalled");

  // A report that opens a code send is followed at once by a digit beat
  a_send_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tready && !m_axis_tuser && !m_axis_tlast |=>
      m_axis_tvalid && m_axis_tuser)
    else $error("digit beat missing after send report");

  // A report beat comes only after the previous run has closed
  a_report_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tready && m_axis_tuser && !m_axis_tlast |=>
      m_axis_tvalid && m_axis_tuser)
    else $error("code run broken before its last digit");

  // Upper tdata padding stays zero
  a_pad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[7:4] == 4'b0000)
    else $error("output padding not zero");

endmodule

bind keypad_debounce_code_entry_unit kdce_checker u_kdce_checker (.*);
